>>> rtl/proximity_gain_control_unit_assert.svh
// ----------------------------------------------------------------------------
// Proximity gain control assertion macros
// Clocked assertion wrappers shared by the checker of the gain control unit.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_GAIN_CONTROL_UNIT_ASSERT_SVH
`define PROXIMITY_GAIN_CONTROL_UNIT_ASSERT_SVH

// Checked on every rising clock edge outside reset.
`define PGC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define PGC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

>>> rtl/pgc_pkg.sv
// ----------------------------------------------------------------------------
// Proximity gain control package
// Field types, widths, codes and the exponent gain table for the unit.
// ----------------------------------------------------------------------------
package pgc_pkg;

  localparam int unsigned EXP_TABLE_ENTRIES = 64;
  localparam int unsigned EXP_SEGS = EXP_TABLE_ENTRIES - 1;
  localparam int unsigned IDX_W = $clog2(EXP_TABLE_ENTRIES);

  localparam int unsigned KIND_W = 2;
  localparam int unsigned COORD_W = 24;
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned MUL_W = 24;
  localparam int unsigned SQ_W = 2 * MUL_W;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned P_W = FRAC_W + 1;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W = $clog2(FRAC_W + 1);

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_OFF = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR = 2'd1;

  localparam logic [LIMIT_W-1:0] NEAR_RESET = 24'd0;
  localparam logic [LIMIT_W-1:0] FAR_RESET = 24'd40960;

  localparam logic [P_W-1:0] P_ONE = {1'b1, {FRAC_W{1'b0}}};
  localparam logic [31:0] ROUND_HALF = 32'd32768;

  localparam longint unsigned LN50_Q31 = 64'd8401005435;
  localparam longint unsigned ONE_Q31 = 64'd2147483648;
  localparam longint unsigned GAIN_ONE = 64'd32768;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] rel_x;
    logic signed [COORD_W-1:0] rel_y;
    logic signed [COORD_W-1:0] rel_z;
  } item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              on_event;
    logic              off_event;
  } result_t;

  // Table entry i holds 50^(-(N-1-i)/(N-1)) in Q1.15, evaluated as the
  // eighth power of a truncated series for exp(-a/8).
  function automatic logic [GAIN_W-1:0] gain_entry(input int unsigned i);
    longint unsigned a;
    longint unsigned y;
    longint unsigned term;
    longint unsigned r;
    longint unsigned g;
    longint sum;
    int unsigned k;
    int unsigned s;
    a = (LN50_Q31 * 64'(EXP_SEGS - i)) / EXP_SEGS;
    y = a >> 3;
    term = ONE_Q31;
    sum = longint'(ONE_Q31);
    for (k = 1; k <= 14; k++) begin
      term = ((term * y) >> 31) / 64'(k);
      if (k[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = 64'(sum);
    if (r > ONE_Q31) begin
      r = ONE_Q31;
    end
    for (s = 0; s < 3; s++) begin
      r = (r * r + (ONE_Q31 >> 1)) >> 31;
      if (r > ONE_Q31) begin
        r = ONE_Q31;
      end
    end
    g = (r + 64'd32768) >> 16;
    if (g > GAIN_ONE) begin
      g = GAIN_ONE;
    end
    return g[GAIN_W-1:0];
  endfunction

endpackage

>>> rtl/pgc_div.sv
// ----------------------------------------------------------------------------
// Proximity gain control divider
// Restoring divider giving the fraction of the squared-distance span from near to
// far, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pgc_div import pgc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SQ_W-1:0]   d2,
  input  logic [SQ_W-1:0]   n2,
  input  logic [SQ_W-1:0]   f2,
  output logic              done,
  output logic [FRAC_W-1:0] quot
);

  logic [SQ_W-1:0]  rem;
  logic [SQ_W-1:0]  span;
  logic [SQ_W:0]    rem_shift;
  logic [SQ_W:0]    rem_next;
  logic             fits;
  logic [CNT_W-1:0] count;
  logic             busy;

  assign rem_shift = {rem, 1'b0};
  assign fits = rem_shift >= {1'b0, span};
  assign rem_next = fits ? (rem_shift - {1'b0, span}) : rem_shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CNT_W'(FRAC_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= d2 - n2;
      span <= f2 - n2;
      quot <= '0;
    end else if (busy) begin
      rem <= rem_next[SQ_W-1:0];
      quot <= {quot[FRAC_W-2:0], fits};
    end
  end

endmodule

>>> rtl/proximity_gain_control_unit.sv
// ----------------------------------------------------------------------------
// Proximity gain control unit
// From item transfer to result the unit steps through the shared 24x24
// multiplier passes, the 16-step divider and the table lookup; the divider is
// skipped when the distance lies inside near or beyond far. The next item is
// taken once the unit is back in its idle state after the result is loaded,
// later while the previous result waits. Reset clears the status to off and
// loads near 0 and far 40960; the gain table is constant.
// ----------------------------------------------------------------------------
module proximity_gain_control_unit import pgc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  item_t                item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output result_t              result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]   cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_X,
    S_SQ_Y,
    S_SQ_Z,
    S_SQ_NEAR,
    S_SQ_FAR,
    S_LIMIT,
    S_DECIDE,
    S_DIVIDE,
    S_POS,
    S_INDEX,
    S_INTERP,
    S_FINISH
  } state_t;

  function automatic logic [COORD_W-1:0] magnitude(input logic signed [COORD_W-1:0] v);
    return v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
  endfunction

  state_t state;
  logic   running;
  logic   running_next;
  logic   on_ev;
  logic   off_ev;

  logic [LIMIT_W-1:0] near_limit;
  logic [LIMIT_W-1:0] far_limit;

  logic [COORD_W-1:0] ax;
  logic [COORD_W-1:0] ay;
  logic [COORD_W-1:0] az;
  logic [SQ_W-1:0]    d2;
  logic [SQ_W-1:0]    n2;
  logic [SQ_W-1:0]    f2;
  logic               far_above;
  logic               inside_near;
  logic [P_W-1:0]     p;

  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [SQ_W-1:0]  mul_out;
  logic [SQ_W-1:0]  prod;

  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] quot;

  logic [GAIN_W-1:0] gain_rom [EXP_TABLE_ENTRIES];
  logic [IDX_W-1:0]  pos_idx;
  logic [IDX_W-1:0]  hi_idx;
  logic              at_top;
  logic [GAIN_W-1:0] lo_val;
  logic [GAIN_W-1:0] hi_val;
  logic [GAIN_W-1:0] lo;
  logic [GAIN_W-1:0] diff;
  logic [FRAC_W-1:0] frac;
  logic [31:0]       rounded;
  logic [GAIN_W-1:0] gain_value;
  logic              item_xfer;

  for (genvar g = 0; g < EXP_TABLE_ENTRIES; g++) begin : g_rom
    assign gain_rom[g] = gain_entry(g);
  end

  assign item_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign item_xfer = item_valid && item_ready;

  always_comb begin
    case (item.kind)
      KIND_ON: running_next = 1'b1;
      KIND_OFF: running_next = 1'b0;
      default: running_next = running;
    endcase
  end

  always_comb begin
    case (state)
      S_SQ_X: begin
        mul_a = ax;
        mul_b = ax;
      end
      S_SQ_Y: begin
        mul_a = ay;
        mul_b = ay;
      end
      S_SQ_Z: begin
        mul_a = az;
        mul_b = az;
      end
      S_SQ_NEAR: begin
        mul_a = MUL_W'(near_limit);
        mul_b = MUL_W'(near_limit);
      end
      S_SQ_FAR: begin
        mul_a = MUL_W'(far_limit);
        mul_b = MUL_W'(far_limit);
      end
      S_POS: begin
        mul_a = MUL_W'(p);
        mul_b = MUL_W'(EXP_SEGS);
      end
      S_INTERP: begin
        mul_a = MUL_W'(diff);
        mul_b = MUL_W'(frac);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  assign pos_idx = prod[FRAC_W +: IDX_W];
  assign at_top = pos_idx >= IDX_W'(EXP_SEGS);
  assign hi_idx = at_top ? pos_idx : pos_idx + IDX_W'(1);
  assign lo_val = gain_rom[pos_idx];
  assign hi_val = gain_rom[hi_idx];

  assign rounded = prod[31:0] + ROUND_HALF;
  assign gain_value = lo + rounded[31:16];

  assign div_start = (state == S_DECIDE) && !inside_near && far_above && (d2 < f2);

  pgc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .d2    (d2),
    .n2    (n2),
    .f2    (f2),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      running <= 1'b0;
      result_valid <= 1'b0;
      near_limit <= NEAR_RESET;
      far_limit <= FAR_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_NEAR: near_limit <= cfg_data;
          CFG_FAR: far_limit <= cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready && (state != S_FINISH)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_xfer) begin
            running <= running_next;
            state <= S_SQ_X;
          end
        end
        S_SQ_X: state <= S_SQ_Y;
        S_SQ_Y: state <= S_SQ_Z;
        S_SQ_Z: state <= S_SQ_NEAR;
        S_SQ_NEAR: state <= S_SQ_FAR;
        S_SQ_FAR: state <= S_LIMIT;
        S_LIMIT: state <= S_DECIDE;
        S_DECIDE: state <= div_start ? S_DIVIDE : S_POS;
        S_DIVIDE: begin
          if (div_done) begin
            state <= S_POS;
          end
        end
        S_POS: state <= S_INDEX;
        S_INDEX: state <= S_INTERP;
        S_INTERP: state <= S_FINISH;
        S_FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            result.gain <= gain_value;
            result.on_event <= on_ev;
            result.off_event <= off_ev;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_out;
    case (state)
      S_IDLE: begin
        if (item_xfer) begin
          ax <= magnitude(item.rel_x);
          ay <= magnitude(item.rel_y);
          az <= magnitude(item.rel_z);
          on_ev <= (item.kind == KIND_ON);
          off_ev <= !running_next;
        end
      end
      S_SQ_Y: d2 <= prod;
      S_SQ_Z: d2 <= d2 + prod;
      S_SQ_NEAR: d2 <= d2 + prod;
      S_SQ_FAR: n2 <= prod;
      S_LIMIT: begin
        f2 <= prod;
        far_above <= prod > n2;
        inside_near <= d2 <= n2;
      end
      S_DECIDE: p <= inside_near ? P_ONE : '0;
      S_DIVIDE: begin
        if (div_done) begin
          p <= P_ONE - P_W'(quot);
        end
      end
      S_INDEX: begin
        lo <= lo_val;
        frac <= prod[FRAC_W-1:0];
        diff <= (at_top || hi_val < lo_val) ? '0 : hi_val - lo_val;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/pgc_checker.sv
// ----------------------------------------------------------------------------
// Proximity gain control checker
// Port-level assertions for the gain control unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "proximity_gain_control_unit_assert.svh"

module pgc_checker import pgc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  `PGC_ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "Result valid after reset")
  `PGC_ASSERT(a_result_held, result_valid && !result_ready |=> result_valid, "Result dropped")
  `PGC_ASSERT(a_busy_after_item, item_valid && item_ready |=> !item_ready, "Ready while busy")
  `PGC_ASSERT(a_gain_range, result_valid |-> result.gain != '0 && result.gain <= 16'd32768, "Gain out of range")
  `PGC_ASSERT(a_event_excl, result_valid |-> !(result.on_event && result.off_event), "Both events set")

endmodule

bind proximity_gain_control_unit pgc_checker u_pgc_checker (.*);
